// ===== src/ubh_pkg.sv =====
package ubh_pkg;

   localparam int BINS       = 1024;
   localparam int COUNT_BITS = 32;
   localparam int BIN_BITS   = $clog2(BINS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // request kinds
   localparam logic [1:0] KIND_FILL   = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // register indexes
   localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH  = 2'd1;
   localparam logic [1:0] REG_BINS_IN_USE = 2'd2;
   localparam logic [1:0] REG_BIN_SCALE   = 2'd3;

   // write side of the bin store
   typedef struct packed {
      logic                  en;
      logic [BIN_BITS-1:0]   addr;
      logic [COUNT_BITS-1:0] data;
   } ubh_wr_type;

   // read side of the bin store
   typedef struct packed {
      logic                en;
      logic [BIN_BITS-1:0] addr;
   } ubh_rd_type;

endpackage

// ===== src/ubh_bin_ram.sv =====
module ubh_bin_ram
   import ubh_pkg::*;
(
   input  logic                  clock,
   input  ubh_wr_type            wr,
   input  ubh_rd_type            rd,
   output logic [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0] mem [BINS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

// ===== src/uniform_bin_histogram.sv =====
// uniform-bin histogram engine
// request channel (req_*): one request per handshake; tuser carries the kind
// (fill, clear, read, unused), tdata carries the sample and the bin to read.
// response channel (rsp_*): exactly one response per request, in order.
// csr port: a write at any edge with csr_we high sets the register csr_addr
// (0 range_low, 1 range_high, 2 bins_in_use, 3 bin_scale); write only while idle.
// the bin counters live in a single-port-write, registered-read memory. one
// request is worked on at a time:
//   fill  : range check, 32x32 scale multiply, memory read, update and
//           write back, then the response
//   read  : memory read then response
//   clear : a sweep that writes zero to every bin, then the response
//   unused kind : response only, all fields zero
// after reset the same sweep clears all BINS = 1024 bins; no request
// is taken then, csr writes are. the response sits in an output register, so
// a stalled receiver holds it there while the block takes the next request;
// work only stops when that request's response is ready and the register is
// still full.
module uniform_bin_histogram
   import ubh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: tuser = kind[1:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   // request tdata: sample[31:0], bin_select[41:32], zero [47:42]
   input  logic [47:0] req_tdata,
   // response tdata: in_range[0], bin_hit[10:1], bin_count[42:11],
   // saturated[43], zero [47:44]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RANGE  = 3'd1;
   localparam logic [2:0] ST_MULT   = 3'd2;
   localparam logic [2:0] ST_ADDR   = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;

   localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(BINS - 1);

   // configuration registers
   logic signed [31:0] range_low_ff;
   logic signed [31:0] range_high_ff;
   logic [10:0]        bins_in_use_ff;
   logic [31:0]        bin_scale_ff;

   // control
   logic [2:0]          state_ff, state_in;
   logic [BIN_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                clr_report_ff, clr_report_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request payload and pipeline registers
   logic [1:0]          kind_ff;
   logic signed [31:0]  sample_ff;
   logic [9:0]          sel_ff;
   logic                in_range_ff, in_range_in;
   logic [31:0]         diff_ff, diff_in;
   logic [63:0]         prod_ff;
   logic [BIN_BITS-1:0] addr_ff, addr_in;
   logic [47:0]         rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  out_free;
   logic                  load_rsp;
   logic signed [31:0]    lo, hi;
   logic [BIN_BITS-1:0]   last_in_use;
   logic [47:0]           idx_wide;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] new_count;
   logic [COUNT_BITS-1:0] res_count;
   logic [BIN_BITS-1:0]   sel_addr;
   logic                  sel_ok;
   logic                  res_in_range;
   logic [9:0]            res_hit;
   ubh_wr_type            wr;
   ubh_rd_type            rd;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= 32'sd0;
         range_high_ff  <= 32'sd65536;
         bins_in_use_ff <= 11'd1024;
         bin_scale_ff   <= 32'd67108864;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_RANGE_LOW:   range_low_ff   <= csr_wdata;
            REG_RANGE_HIGH:  range_high_ff  <= csr_wdata;
            REG_BINS_IN_USE: bins_in_use_ff <= csr_wdata[10:0];
            REG_BIN_SCALE:   bin_scale_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // bounds exchanged when given the wrong way round
   always_comb begin
      if (range_high_ff < range_low_ff) begin
         lo = range_high_ff;
         hi = range_low_ff;
      end else begin
         lo = range_low_ff;
         hi = range_high_ff;
      end
   end

   assign in_range_in = (sample_ff >= lo) && (sample_ff <= hi);
   // difference fits in 32 bits unsigned once the sample is in range
   assign diff_in     = 32'(sample_ff - lo);

   // last bin in use: zero acts as one bin, above BINS acts as BINS
   always_comb begin
      priority if (bins_in_use_ff == 11'd0) begin
         last_in_use = '0;
      end else if (32'(bins_in_use_ff) > BINS) begin
         last_in_use = LAST_BIN;
      end else begin
         last_in_use = BIN_BITS'(bins_in_use_ff - 11'd1);
      end
   end

   // top of range and anything past the last bin land in the last bin
   assign idx_wide = prod_ff[63:16];
   assign addr_in  = (idx_wide > 48'(last_in_use)) ? last_in_use : idx_wide[BIN_BITS-1:0];

   assign sel_ok   = (32'(sel_ff) < BINS);
   assign sel_addr = BIN_BITS'(sel_ff);

   // counter update, saturating
   assign new_count = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

   always_comb begin
      res_in_range = 1'b0;
      res_hit      = '0;
      res_count    = '0;
      unique case (kind_ff)
         KIND_FILL: begin
            if (in_range_ff) begin
               res_in_range = 1'b1;
               res_hit      = 10'(addr_ff);
               res_count    = new_count;
            end
         end
         KIND_READ: begin
            res_hit = sel_ff;
            if (sel_ok) begin
               res_count = rd_data;
            end
         end
         KIND_CLEAR, KIND_UNUSED: ;
         default: ;
      endcase
   end

   assign load_rsp = (state_ff == ST_UPDATE) && out_free;

   always_comb begin
      rsp_data_in = {4'd0, (res_count == COUNT_MAX) && res_in_range
                     || (kind_ff == KIND_READ && sel_ok && res_count == COUNT_MAX),
                     32'(res_count), res_hit, res_in_range};
   end

   // memory ports; a fill reads the bin index as it is being registered
   always_comb begin
      wr.en   = 1'b0;
      wr.addr = addr_ff;
      wr.data = new_count;
      if (state_ff == ST_CLEAR) begin
         wr.en   = 1'b1;
         wr.addr = clr_addr_ff;
         wr.data = '0;
      end else if (load_rsp && kind_ff == KIND_FILL && in_range_ff) begin
         wr.en = 1'b1;
      end
      rd.en   = (state_ff == ST_ADDR);
      rd.addr = (kind_ff == KIND_READ) ? sel_addr : addr_in;
   end

   ubh_bin_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_report_in = clr_report_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  KIND_FILL:   state_in = ST_RANGE;
                  KIND_READ:   state_in = ST_ADDR;
                  KIND_UNUSED: state_in = ST_UPDATE;
                  KIND_CLEAR: begin
                     state_in      = ST_CLEAR;
                     clr_addr_in   = '0;
                     clr_report_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_RANGE:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_BIN) begin
               // the reset sweep gives no response
               state_in = clr_report_ff ? ST_UPDATE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         clr_report_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_report_ff <= clr_report_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_tuser;
         sample_ff <= req_tdata[31:0];
         sel_ff    <= req_tdata[41:32];
      end
      if (state_ff == ST_RANGE) begin
         in_range_ff <= in_range_in;
         diff_ff     <= diff_in;
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= 64'(diff_ff) * 64'(bin_scale_ff);
      end
      if (state_ff == ST_ADDR && kind_ff == KIND_FILL) begin
         addr_ff <= addr_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== tb/tb_uniform_bin_histogram.sv =====
module tb_uniform_bin_histogram;
   import ubh_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 156;

   // one response as the block reports it
   typedef struct {
      logic                  in_range;
      logic [BIN_BITS-1:0]   bin_hit;
      logic [31:0]           bin_count;
      logic                  saturated;
   } bin_result_type;

   // tracks the bin store and the register copies, predicts each response
   class histogram_scoreboard;
      logic [COUNT_BITS-1:0] counts [BINS];
      logic signed [31:0]    low_bound;
      logic signed [31:0]    high_bound;
      logic [10:0]           bins_used;
      logic [31:0]           scale;
      logic [BIN_BITS-1:0]   last_fill_bin;
      bin_result_type        expected_results [$];
      int                    mismatches;

      function new();
         foreach (counts[i]) counts[i] = '0;
         low_bound     = 32'sd0;
         high_bound    = 32'sd65536;
         bins_used     = 11'd1024;
         scale         = 32'd67108864;
         last_fill_bin = '0;
         mismatches    = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_RANGE_LOW:   low_bound  = val;
            REG_RANGE_HIGH:  high_bound = val;
            REG_BINS_IN_USE: bins_used  = val[10:0];
            REG_BIN_SCALE:   scale      = val;
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] kind, logic [47:0] data);
         bin_result_type     r;
         logic signed [31:0] x, lo, hi, t;
         logic [31:0]        d32;
         logic [63:0]        idx, eff;
         logic [BIN_BITS-1:0] sel;
         r.in_range  = 1'b0;
         r.bin_hit   = '0;
         r.bin_count = '0;
         r.saturated = 1'b0;
         case (kind)
            KIND_FILL: begin
               x  = data[31:0];
               lo = low_bound;
               hi = high_bound;
               // bounds given the wrong way round are used swapped
               if (hi < lo) begin
                  t  = lo;
                  lo = hi;
                  hi = t;
               end
               if (x >= lo && x <= hi) begin
                  d32 = x - lo;
                  idx = ({32'b0, d32} * {32'b0, scale}) >> 16;
                  eff = (bins_used == 0) ? 64'd1 :
                        (bins_used > BINS) ? 64'(BINS) : 64'(bins_used);
                  // top of range and overshoot land in the last bin in use
                  if (idx > eff - 1) idx = eff - 1;
                  if (counts[idx] != COUNT_MAX) counts[idx] = counts[idx] + 1'b1;
                  r.in_range    = 1'b1;
                  r.bin_hit     = idx[BIN_BITS-1:0];
                  r.bin_count   = counts[idx][31:0];
                  r.saturated   = (counts[idx] == COUNT_MAX);
                  last_fill_bin = idx[BIN_BITS-1:0];
               end
            end
            KIND_CLEAR: begin
               foreach (counts[i]) counts[i] = '0;
            end
            KIND_READ: begin
               sel         = data[41:32];
               r.bin_hit   = sel;
               r.bin_count = counts[sel][31:0];
               r.saturated = (counts[sel] == COUNT_MAX);
            end
            default: ;
         endcase
         expected_results.push_back(r);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
      endfunction

      function void check_response(logic [47:0] data);
         bin_result_type e;
         if (expected_results.size() == 0) begin
            flag("response with nothing outstanding", 32'h0, data[31:0]);
            return;
         end
         e = expected_results.pop_front();
         if (data[0] !== e.in_range)      flag("in_range", e.in_range, data[0]);
         if (data[10:1] !== e.bin_hit)    flag("bin_hit", e.bin_hit, data[10:1]);
         if (data[42:11] !== e.bin_count) flag("bin_count", e.bin_count, data[42:11]);
         if (data[43] !== e.saturated)    flag("saturated", e.saturated, data[43]);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   histogram_scoreboard sb = new();

   // percent chance per cycle that the sender idles or the receiver stalls
   int idle_pct  = 0;
   int stall_pct = 0;
   int cycles    = 0;

   uniform_bin_histogram i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // handshakes are sampled on the rising edge; responses are checked before
   // the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("uniform_bin_histogram test failed");
         $finish;
      end
   end

   // called just after a falling edge, returns just after a falling edge;
   // valid stays high into the next call unless that call idles first
   task automatic send_request(input logic [1:0] kind, input logic [31:0] sample,
                               input logic [BIN_BITS-1:0] sel);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, sel, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding response come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // block must be idle; one register per cycle
   task automatic write_settings(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [31:0] nbins, input logic [31:0] scl);
      logic [31:0] vals [4];
      vals = '{lo, hi, nbins, scl};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 2'(i);
         csr_wdata <= vals[i];
         sb.write_register(2'(i), vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // mostly inside the (possibly swapped) range, with bounds, neighbors and noise
   function automatic logic [31:0] pick_sample();
      logic signed [31:0] lo, hi, t;
      logic [32:0]        width;
      logic [63:0]        off;
      int                 r;
      lo = sb.low_bound;
      hi = sb.high_bound;
      if (hi < lo) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      width = {1'b0, 32'(hi - lo)};
      r = $urandom_range(99);
      if (r < 8)  return lo;
      if (r < 16) return hi;
      if (r < 26) return $urandom;
      if (r < 29) return lo - 1;
      if (r < 32) return hi + 1;
      if (r < 45) return lo + ($urandom % ((width > 33'd65535) ? 32'd65536 : width + 1));
      off = ({32'b0, $urandom} * {31'b0, width + 33'd1}) >> 32;
      return lo + off[31:0];
   endfunction

   task automatic run_random(input int count);
      int          r;
      logic [1:0]  kind;
      logic [BIN_BITS-1:0] sel;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(199);
         if (r < 2)       kind = KIND_CLEAR;
         else if (r < 8)  kind = KIND_UNUSED;
         else if (r < 56) kind = KIND_READ;
         else             kind = KIND_FILL;
         sel = ($urandom_range(1) == 1) ? sb.last_fill_bin : BIN_BITS'($urandom_range(BINS - 1));
         send_request(kind, (kind == KIND_FILL) ? pick_sample() : $urandom, sel);
      end
   endtask

   // reset settings: scale 2^26 puts every nonzero offset past the last bin
   task automatic run_directed();
      send_request(KIND_READ, 32'h0, 10'd0);
      send_request(KIND_READ, 32'hFFFF_FFFF, 10'd1023);
      send_request(KIND_FILL, 32'd0, 10'h3FF);          // lower bound, bin 0
      send_request(KIND_FILL, 32'd65536, 10'd0);        // upper bound
      send_request(KIND_FILL, 32'd1, 10'd0);            // index past last bin
      send_request(KIND_FILL, 32'hFFFF_FFFF, 10'd0);    // just below range
      send_request(KIND_FILL, 32'd65537, 10'd0);        // just above range
      send_request(KIND_FILL, 32'h7FFF_FFFF, 10'd0);
      send_request(KIND_FILL, 32'h8000_0000, 10'd0);
      send_request(KIND_FILL, 32'd0, 10'd0);
      send_request(KIND_READ, 32'h0, 10'd0);
      send_request(KIND_READ, 32'h0, 10'd1023);
      send_request(KIND_READ, 32'h0, 10'd512);
      send_request(KIND_UNUSED, 32'hFFFF_FFFF, 10'h3FF);
      send_request(KIND_UNUSED, 32'h0, 10'h0);
      send_request(KIND_CLEAR, 32'h5555_AAAA, 10'h2AA);
      send_request(KIND_READ, 32'h0, 10'd0);
      send_request(KIND_READ, 32'h0, 10'd1023);
      send_request(KIND_FILL, 32'd65536, 10'd0);
      send_request(KIND_READ, 32'hAAAA_5555, 10'd1023);
   endtask

   // register settings for each phase after the first
   task automatic configure_phase(input int p);
      logic [31:0] a, b, nb, span;
      logic [63:0] scl;
      case (p)
         1: write_settings(-32'sd32768, 32'sd32767, 32'd64, 32'd64);
         2: write_settings(32'sd100000, -32'sd100000, 32'd0, 32'hFFFF_FFFF); // swapped, 0 bins
         3: write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'd2047, 32'd1);   // full span
         4: write_settings(32'd1000, 32'd1000 + 32'd16383, 32'd1024, 32'd4096);
         5: write_settings(32'd5000, 32'd5000, 32'd1, 32'd0);                // single point
         default: begin
            a    = $urandom;
            b    = a + $urandom_range(1, 1 << 20);
            nb   = $urandom_range(1, BINS);
            span = (b > a) ? b - a : a - b;
            scl  = ({32'b0, nb} << 16) / ({32'b0, span} + 64'd1);
            write_settings(a, b, nb, scl[31:0] + 32'($urandom_range(0, 3)));
         end
      endcase
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = KIND_FILL;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_RANGE_LOW;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         // idling pattern: none, sender only, receiver only, both
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         if (p > 0) begin
            drain_responses();
            configure_phase(p);
            if ($urandom_range(1) == 1) send_request(KIND_CLEAR, $urandom, 10'd0);
         end
         run_random(ITEMS_PER_PHASE);
      end
      drain_responses();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("uniform_bin_histogram test passed");
      end else begin
         $display("uniform_bin_histogram test failed");
      end
      $finish;
   end

endmodule

// ===== uniform_bin_histogram.f =====
src/ubh_pkg.sv
src/ubh_bin_ram.sv
src/uniform_bin_histogram.sv
tb/tb_uniform_bin_histogram.sv
